// File: design/b64d_pkg.sv
package b64d_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SECOND,
    PH_THIRD,
    PH_FOURTH
  } phase_t;

  typedef struct packed {
    logic [5:0] sextet;
    logic       is_data;
    logic       is_pad;
    logic       is_last;
  } b64d_entry_t;

  typedef struct packed {
    logic byte_valid;
    logic [7:0] data_byte;
    logic message_end;
    logic malformed;
  } b64d_result_t;

endpackage

// File: design/base64_stream_decoder.sv
// Streaming Base64 decoder for the standard alphabet, taking one character per
// item and returning exactly one result item per character, in order. It
// sustains one item per clock cycle in both directions while the item queue
// is not full and results are popped. An accepted item passes in turn the
// combinational character classifier, the item queue of QUEUE_DEPTH
// entries and the result register. A byte is produced on the second, third and
// fourth data character of each group, and the result for the last character
// of a message carries message_end together with the malformed flag for the
// whole message. Bytes already delivered from a message that turns out
// malformed must be discarded.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       in_is_last,
  output logic       empty,
  input  logic       pop,
  output logic       out_byte_valid,
  output logic [7:0] out_data_byte,
  output logic       out_message_end,
  output logic       out_malformed
);

  b64d_entry_t  front_entry;
  b64d_entry_t  head_entry;
  logic         q_empty;
  logic         q_take;
  b64d_result_t result;

  b64d_front u_front (
    .in_char    (in_char),
    .in_is_last (in_is_last),
    .entry      (front_entry)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push),
    .wr_entry (front_entry),
    .full     (full),
    .rd_en    (q_take),
    .rd_entry (head_entry),
    .empty    (q_empty)
  );

  b64d_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head_entry),
    .head_empty   (q_empty),
    .head_take    (q_take),
    .result       (result),
    .result_empty (empty),
    .result_pop   (pop)
  );

  assign out_byte_valid  = result.byte_valid;
  assign out_data_byte   = result.data_byte;
  assign out_message_end = result.message_end;
  assign out_malformed   = result.malformed;

`ifndef NO_ASSERTIONS
  a_malformed_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (!out_malformed || out_message_end))
    else $error("malformed flag set on a result that does not end a message");

  a_no_byte_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_byte_valid) |-> (out_data_byte == 8'h00))
    else $error("data byte is nonzero on a result without a byte");

  a_push_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && q_empty) |=> !q_empty)
    else $error("accepted item did not arrive in the item queue");
`endif

endmodule

// File: design/b64d_front.sv
module b64d_front
  import b64d_pkg::*;
(
  input  logic [7:0]  in_char,
  input  logic        in_is_last,
  output b64d_entry_t entry
);

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [5:0] SEXTET_PLUS  = 6'h3E;
  localparam logic [5:0] SEXTET_SLASH = 6'h3F;

  logic [7:0] diff;

  always_comb begin
    diff          = 8'h00;
    entry.sextet  = 6'h00;
    entry.is_data = 1'b1;
    entry.is_pad  = (in_char == CHAR_PAD);
    entry.is_last = in_is_last;
    if (in_char inside {[8'h41:8'h5A]}) begin
      diff = in_char - 8'h41;
      entry.sextet = diff[5:0];
    end else if (in_char inside {[8'h61:8'h7A]}) begin
      diff = in_char - 8'h47;
      entry.sextet = diff[5:0];
    end else if (in_char inside {[8'h30:8'h39]}) begin
      diff = in_char + 8'h04;
      entry.sextet = diff[5:0];
    end else if (in_char == CHAR_PLUS) begin
      entry.sextet = SEXTET_PLUS;
    end else if (in_char == CHAR_SLASH) begin
      entry.sextet = SEXTET_SLASH;
    end else begin
      entry.is_data = 1'b0;
    end
  end

endmodule

// File: design/b64d_queue.sv
module b64d_queue
  import b64d_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  b64d_entry_t wr_entry,
  output logic        full,
  input  logic        rd_en,
  output b64d_entry_t rd_entry,
  output logic        empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  b64d_entry_t      mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_wr, do_rd;

  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && !empty;
  assign rd_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// File: design/b64d_back.sv
module b64d_back
  import b64d_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  b64d_entry_t  head,
  input  logic         head_empty,
  output logic         head_take,
  output b64d_result_t result,
  output logic         result_empty,
  input  logic         result_pop
);

  phase_t       phase_r, phase_nxt;
  logic [5:0]   residue_r, residue_nxt;
  logic [1:0]   len_r, len_nxt;
  logic [1:0]   pad_r, pad_nxt;
  logic         err_r, err_nxt;
  logic         out_valid_r, out_valid_nxt;
  b64d_result_t result_r, result_nxt;

  assign head_take    = !head_empty && (!out_valid_r || result_pop);
  assign result       = result_r;
  assign result_empty = !out_valid_r;

  always_comb begin
    phase_nxt   = phase_r;
    residue_nxt = residue_r;
    len_nxt     = len_r;
    pad_nxt     = pad_r;
    err_nxt     = err_r;
    result_nxt  = result_r;
    out_valid_nxt = out_valid_r && !result_pop;
    if (head_take) begin
      out_valid_nxt = 1'b1;
      result_nxt    = '0;
      len_nxt       = len_r + 2'd1;
      if (head.is_pad) begin
        if (pad_r >= 2'd2) begin
          err_nxt = 1'b1;
        end else begin
          pad_nxt = pad_r + 2'd1;
        end
      end else if (!head.is_data || pad_r != 2'd0) begin
        err_nxt = 1'b1;
      end else begin
        case (phase_r)
          PH_FIRST: begin
            residue_nxt = head.sextet;
            phase_nxt   = PH_SECOND;
          end
          PH_SECOND: begin
            result_nxt.data_byte  = {residue_r, head.sextet[5:4]};
            result_nxt.byte_valid = 1'b1;
            residue_nxt = {2'b00, head.sextet[3:0]};
            phase_nxt   = PH_THIRD;
          end
          PH_THIRD: begin
            result_nxt.data_byte  = {residue_r[3:0], head.sextet[5:2]};
            result_nxt.byte_valid = 1'b1;
            residue_nxt = {4'b0000, head.sextet[1:0]};
            phase_nxt   = PH_FOURTH;
          end
          PH_FOURTH: begin
            result_nxt.data_byte  = {residue_r[1:0], head.sextet};
            result_nxt.byte_valid = 1'b1;
            residue_nxt = 6'h00;
            phase_nxt   = PH_FIRST;
          end
          default: begin
            phase_nxt = PH_FIRST;
          end
        endcase
      end
      if (head.is_last) begin
        result_nxt.message_end = 1'b1;
        result_nxt.malformed   = err_nxt || (len_nxt == 2'd1) || (phase_nxt == PH_SECOND);
        phase_nxt   = PH_FIRST;
        residue_nxt = 6'h00;
        len_nxt     = 2'd0;
        pad_nxt     = 2'd0;
        err_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FIRST;
      residue_r   <= 6'h00;
      len_r       <= 2'd0;
      pad_r       <= 2'd0;
      err_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      residue_r   <= residue_nxt;
      len_r       <= len_nxt;
      pad_r       <= pad_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

endmodule
